/* hdl/grbc_pkg.sv */
`default_nettype none

package grbc_pkg;

    localparam int LINE_WIDTH      = 512;
    localparam int BAND_ROWS       = 64;
    localparam int MAX_GLYPH_WIDTH = 32;

    localparam int ROW_BITS_W = 32;
    localparam int GROW_W     = 6;
    localparam int COORD_W    = 11;
    localparam int GW_W       = 6;
    localparam int GH_W       = 7;
    localparam int ZONE_W     = 10;
    localparam int COLOUR_W   = 16;
    localparam int OFFSET_W   = 15;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // wide enough for coordinate sums and differences
    localparam int CALC_W     = 13;

    localparam int BAND_ROW_W = (BAND_ROWS > 1) ? $clog2(BAND_ROWS) : 1;
    localparam int COL_W      = $clog2(MAX_GLYPH_WIDTH);
    localparam int COL_CNT_W  = $clog2(MAX_GLYPH_WIDTH + 1);

    localparam logic [ZONE_W-1:0]   ZONE_START_RST = ZONE_W'(0);
    localparam logic [ZONE_W-1:0]   ZONE_END_RST   = ZONE_W'(64);
    localparam logic [COLOUR_W-1:0] PEN_COLOUR_RST = COLOUR_W'(16'hFFFF);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZONE_START = 2'd0,
        CFG_ZONE_END   = 2'd1,
        CFG_PEN_COLOUR = 2'd2
    } t_cfg_idx;

    // row after vertical clip and column window setup
    typedef struct packed {
        logic                        ok;
        logic [ROW_BITS_W-1:0]       bits;
        logic [BAND_ROW_W-1:0]       band_row;
        logic signed [COORD_W-1:0]   xs;
        logic [COL_CNT_W-1:0]        lo_col;
        logic [COL_CNT_W-1:0]        end_col;
    } t_row;

    // visible ink columns and offset of column zero
    typedef struct packed {
        logic [MAX_GLYPH_WIDTH-1:0]  mask;
        logic [OFFSET_W-1:0]         base;
    } t_span;

endpackage

`default_nettype wire

/* hdl/grbc_row_clip.sv */
`default_nettype none

module grbc_row_clip (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire logic [grbc_pkg::ROW_BITS_W-1:0]       i_row_bits,
    input  wire logic [grbc_pkg::GROW_W-1:0]           i_glyph_row,
    input  wire logic signed [grbc_pkg::COORD_W-1:0]   i_x_start,
    input  wire logic signed [grbc_pkg::COORD_W-1:0]   i_y_start,
    input  wire logic [grbc_pkg::GW_W-1:0]             i_glyph_width,
    input  wire logic [grbc_pkg::GH_W-1:0]             i_glyph_height,
    input  wire logic [grbc_pkg::ZONE_W-1:0]           i_zone_start,
    input  wire logic [grbc_pkg::ZONE_W-1:0]           i_zone_end,
    input  wire logic                                  i_down_free,
    output      logic                                  o_free,
    output      logic                                  o_valid,
    output      grbc_pkg::t_row                        o_row
);
    import grbc_pkg::*;

    logic                       r_valid;
    t_row                       r_row;
    t_row                       n_row;

    logic signed [CALC_W-1:0]   y;
    logic signed [CALC_W-1:0]   zs;
    logic signed [CALC_W-1:0]   ze;
    logic signed [CALC_W-1:0]   diff;
    logic signed [CALC_W-1:0]   xs;
    logic signed [CALC_W-1:0]   neg_xs;
    logic signed [CALC_W-1:0]   right;
    logic [COL_CNT_W-1:0]       gw_sat;
    logic [COL_CNT_W-1:0]       lo;
    logic [COL_CNT_W-1:0]       rt;

    always_comb begin
        y      = CALC_W'(i_y_start) + signed'(CALC_W'(i_glyph_row));
        zs     = signed'(CALC_W'(i_zone_start));
        ze     = signed'(CALC_W'(i_zone_end));
        diff   = y - zs;
        xs     = CALC_W'(i_x_start);
        neg_xs = -xs;
        right  = signed'(CALC_W'(LINE_WIDTH)) - xs;

        if (i_glyph_width > GW_W'(MAX_GLYPH_WIDTH)) begin
            gw_sat = COL_CNT_W'(MAX_GLYPH_WIDTH);
        end else begin
            gw_sat = COL_CNT_W'(i_glyph_width);
        end

        // columns hidden off the left edge
        if (xs >= 0) begin
            lo = '0;
        end else if (neg_xs > signed'(CALC_W'(MAX_GLYPH_WIDTH))) begin
            lo = COL_CNT_W'(MAX_GLYPH_WIDTH);
        end else begin
            lo = COL_CNT_W'(neg_xs);
        end

        // columns left before the right edge of the line
        if (right <= 0) begin
            rt = '0;
        end else if (right > signed'(CALC_W'(gw_sat))) begin
            rt = gw_sat;
        end else begin
            rt = COL_CNT_W'(right);
        end

        n_row.ok       = (CALC_W'(i_glyph_row) < CALC_W'(i_glyph_height)) &&
                         (y >= zs) && (y < ze) &&
                         (diff < signed'(CALC_W'(BAND_ROWS)));
        n_row.bits     = i_row_bits;
        n_row.band_row = diff[BAND_ROW_W-1:0];
        n_row.xs       = i_x_start;
        n_row.lo_col   = lo;
        n_row.end_col  = rt;
    end

    assign o_free  = !r_valid || i_down_free;
    assign o_valid = r_valid;
    assign o_row   = r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

/* hdl/grbc_col_mask.sv */
`default_nettype none

module grbc_col_mask (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire grbc_pkg::t_row   i_row,
    input  wire logic             i_down_free,
    output      logic             o_free,
    output      logic             o_valid,
    output      grbc_pkg::t_span  o_span
);
    import grbc_pkg::*;

    logic                  r_valid;
    t_span                 r_span;
    t_span                 n_span;
    logic [OFFSET_W-1:0]   row_off;

    always_comb begin
        for (int c = 0; c < MAX_GLYPH_WIDTH; c++) begin
            n_span.mask[c] = i_row.ok && i_row.bits[ROW_BITS_W-1-c] &&
                             (COL_CNT_W'(c) >= i_row.lo_col) &&
                             (COL_CNT_W'(c) < i_row.end_col);
        end
        row_off     = OFFSET_W'(i_row.band_row) * OFFSET_W'(LINE_WIDTH);
        // offsets wrap modulo the buffer index width
        n_span.base = row_off + OFFSET_W'(i_row.xs);
    end

    assign o_free  = !r_valid || i_down_free;
    assign o_valid = r_valid;
    assign o_span  = r_span;

    // rows with nothing visible are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid && (n_span.mask != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_span <= n_span;
        end
    end

endmodule

`default_nettype wire

/* hdl/grbc_emit.sv */
`default_nettype none

module grbc_emit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire grbc_pkg::t_span                    i_span,
    input  wire logic [grbc_pkg::COLOUR_W-1:0]      i_pen_colour,
    input  wire logic                               i_out_stall,
    output      logic                               o_free,
    output      logic                               o_out_valid,
    output      logic [grbc_pkg::OFFSET_W-1:0]      o_pixel_offset,
    output      logic [grbc_pkg::COLOUR_W-1:0]      o_pixel_value,
    output      logic                               o_last_write
);
    import grbc_pkg::*;

    logic                          r_em_valid;
    logic [MAX_GLYPH_WIDTH-1:0]    r_mask;
    logic [OFFSET_W-1:0]           r_base;
    logic                          r_out_valid;
    logic [OFFSET_W-1:0]           r_offset;
    logic [COLOUR_W-1:0]           r_value;
    logic                          r_last;

    logic [COL_W-1:0]              idx;
    logic [MAX_GLYPH_WIDTH-1:0]    rest;
    logic                          out_free;
    logic                          emit;
    logic                          done;
    logic                          load;

    // lowest set column goes first
    always_comb begin
        idx = '0;
        for (int c = MAX_GLYPH_WIDTH - 1; c >= 0; c--) begin
            if (r_mask[c]) begin
                idx = COL_W'(c);
            end
        end
    end

    assign rest     = r_mask & (r_mask - MAX_GLYPH_WIDTH'(1));
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = r_em_valid && out_free;
    assign done     = emit && (rest == '0);
    assign o_free   = !r_em_valid || done;
    assign load     = i_valid && o_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid <= 1'b0;
        end else if (load) begin
            r_em_valid <= 1'b1;
        end else if (done) begin
            r_em_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mask <= i_span.mask;
            r_base <= i_span.base;
        end else if (emit) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_offset <= r_base + OFFSET_W'(idx);
            r_value  <= i_pen_colour;
            r_last   <= (rest == '0);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_offset = r_offset;
    assign o_pixel_value  = r_value;
    assign o_last_write   = r_last;

endmodule

`default_nettype wire

/* hdl/glyph_row_blit_clipped_unit.sv */
// Glyph row blitter with clipping.
// Input channel (i_in_valid / o_in_stall): one transaction is one 1-bit glyph
// row with its position, size and row index. Output channel (o_out_valid /
// i_out_stall): one transaction is one band buffer write of the pen colour;
// the final write of a row carries o_last_write.
// The config port (i_cfg_we, i_cfg_index, i_cfg_data) sets zone start, zone
// end and pen colour; write it only while the block is empty.
// Pipeline: row clip, column mask, write sequencer, output register.
// Throughput: the sequencer issues one write per cycle while the receiver
// does not stall, one write per visible ink pixel of a row; rows with no
// visible ink are dropped in the mask stage. Rows enter every cycle while
// the sequencer keeps up.
// Reset (synchronous, active low) empties the pipe and loads zone 0..64 and
// pen colour 0xFFFF. When the receiver stalls, the output holds its write
// and the stall backs up stage by stage to o_in_stall; nothing is lost.
`default_nettype none

module glyph_row_blit_clipped_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [grbc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [grbc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  i_in_valid,
    output      logic                                  o_in_stall,
    input  wire logic [grbc_pkg::ROW_BITS_W-1:0]       i_row_bits,
    input  wire logic [grbc_pkg::GROW_W-1:0]           i_glyph_row,
    input  wire logic signed [grbc_pkg::COORD_W-1:0]   i_x_start,
    input  wire logic signed [grbc_pkg::COORD_W-1:0]   i_y_start,
    input  wire logic [grbc_pkg::GW_W-1:0]             i_glyph_width,
    input  wire logic [grbc_pkg::GH_W-1:0]             i_glyph_height,
    output      logic                                  o_out_valid,
    input  wire logic                                  i_out_stall,
    output      logic [grbc_pkg::OFFSET_W-1:0]         o_pixel_offset,
    output      logic [grbc_pkg::COLOUR_W-1:0]         o_pixel_value,
    output      logic                                  o_last_write
);
    import grbc_pkg::*;

    logic [ZONE_W-1:0]     r_zone_start;
    logic [ZONE_W-1:0]     r_zone_end;
    logic [COLOUR_W-1:0]   r_pen_colour;

    logic                  clip_free;
    logic                  clip_valid;
    t_row                  clip_row;
    logic                  mask_free;
    logic                  mask_valid;
    t_span                 mask_span;
    logic                  emit_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_start <= ZONE_START_RST;
            r_zone_end   <= ZONE_END_RST;
            r_pen_colour <= PEN_COLOUR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ZONE_START: r_zone_start <= i_cfg_data[ZONE_W-1:0];
                CFG_ZONE_END:   r_zone_end   <= i_cfg_data[ZONE_W-1:0];
                CFG_PEN_COLOUR: r_pen_colour <= i_cfg_data[COLOUR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = !clip_free;

    grbc_row_clip u_row_clip (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_row_bits     (i_row_bits),
        .i_glyph_row    (i_glyph_row),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .i_zone_start   (r_zone_start),
        .i_zone_end     (r_zone_end),
        .i_down_free    (mask_free),
        .o_free         (clip_free),
        .o_valid        (clip_valid),
        .o_row          (clip_row)
    );

    grbc_col_mask u_col_mask (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (clip_valid),
        .i_row       (clip_row),
        .i_down_free (emit_free),
        .o_free      (mask_free),
        .o_valid     (mask_valid),
        .o_span      (mask_span)
    );

    grbc_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (mask_valid),
        .i_span         (mask_span),
        .i_pen_colour   (r_pen_colour),
        .i_out_stall    (i_out_stall),
        .o_free         (emit_free),
        .o_out_valid    (o_out_valid),
        .o_pixel_offset (o_pixel_offset),
        .o_pixel_value  (o_pixel_value),
        .o_last_write   (o_last_write)
    );

endmodule

`default_nettype wire
